// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with active-low reset masking.
`define CHK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// Clocked check that also holds during reset.
`define CHK_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// ===== hw/rtl/dwcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dwcs_pkg;

    localparam int DWCS_MEM_WORDS = 65536;
    localparam int REG_COUNT      = 10;
    localparam int REG_IW         = 4;

    localparam logic [19:0] ADDR_LIMIT  = 20'd999999;
    localparam logic [31:0] WORD_LIMIT  = 32'd999999999;
    localparam logic [31:0] DEC_DIVISOR = 32'd1000000;
    // ceil(2^50 / 1000000); quotient = (word * DEC_RECIP) >> 50, exact for 32-bit words
    localparam logic [30:0] DEC_RECIP   = 31'd1125899907;
    localparam logic [19:0] START_RESET = 20'd100;

    localparam logic [2:0] ST_LOADED  = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_EXEC    = 3'd2;
    localparam logic [2:0] ST_WROTE   = 3'd3;
    localparam logic [2:0] ST_HALTED  = 3'd4;
    localparam logic [2:0] ST_ERRSTOP = 3'd5;
    localparam logic [2:0] ST_NOTRUN  = 3'd6;

    localparam logic [1:0] RUN_GO   = 2'd0;
    localparam logic [1:0] RUN_HALT = 2'd1;
    localparam logic [1:0] RUN_ERR  = 2'd2;

    localparam logic [6:0] OPC_ADD   = 7'd1;
    localparam logic [6:0] OPC_SUB   = 7'd2;
    localparam logic [6:0] OPC_MUL   = 7'd3;
    localparam logic [6:0] OPC_DIV   = 7'd4;
    localparam logic [6:0] OPC_LOAD  = 7'd5;
    localparam logic [6:0] OPC_STORE = 7'd6;
    localparam logic [6:0] OPC_READ  = 7'd7;
    localparam logic [6:0] OPC_WRITE = 7'd8;
    localparam logic [6:0] OPC_BR    = 7'd9;
    localparam logic [6:0] OPC_BRN   = 7'd10;
    localparam logic [6:0] OPC_BRZ   = 7'd11;
    localparam logic [6:0] OPC_BRP   = 7'd12;
    localparam logic [6:0] OPC_HALT  = 7'd13;
    localparam logic [6:0] OPC_ERR   = 7'd14;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic               op;
        logic [19:0]        address;
        logic signed [31:0] data;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_value;
        logic               data_used;
        logic [19:0]        next_pc;
    } t_out_word;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== hw/rtl/decimal_word_cpu_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Load word: accepted in idle, then the result is registered in the finish state (S_FIN). Step word:
// fetch, reciprocal decimal split, digit split with operand read, execute, then S_FIN.
// A divide adds a wait in S_DIV on the restoring divider before S_FIN.
// One word at a time: o_stall stays high until the state machine is back in idle.
// Reset: a clearing pass writes zero to all MEM_WORDS memory words, one per cycle,
// before the first word is taken; registers zero, pc = 100, running.
module decimal_word_cpu_step_unit #(
    parameter int MEM_WORDS = dwcs_pkg::DWCS_MEM_WORDS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire dwcs_pkg::t_in_word i_in_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output dwcs_pkg::t_out_word     o_out_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import dwcs_pkg::*;

    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam logic [20:0] MEM_LIM = 21'(MEM_WORDS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FETCH = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_DIGIT = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    logic [3:0]        r_state;
    logic [MEM_AW-1:0] r_clr;
    logic [19:0]       r_start;
    logic [19:0]       r_pc;
    logic [1:0]        r_run;
    logic [31:0]       r_regs [REG_COUNT];
    logic [31:0]       r_mem [MEM_WORDS];
    logic [31:0]       r_rdata;
    logic [31:0]       r_data;
    logic [9:0]        r_q;
    logic [19:0]       r_a;
    logic [6:0]        r_opc;
    logic [REG_IW-1:0] r_reg;
    logic              r_neg;
    t_out_word         r_res;
    t_out_word         r_out;
    logic              r_ovalid;

    logic              accept;
    logic              cfg_wr;
    logic              load_ok;
    logic              pc_ok;
    logic              word_bad;
    logic              opnd_fault;
    logic              ex_fault;
    logic [2:0]        ex_status;
    logic [19:0]       ex_npc;
    logic [31:0]       rv;
    logic [31:0]       m;
    logic [62:0]       dec_prod;
    logic [31:0]       dec_rem;
    logic [17:0]       q_scaled;
    logic [6:0]        opc_c;
    logic [3:0]        reg_c;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [31:0]       mem_wd;
    logic [MEM_AW-1:0] mem_ra;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata  = (paddr[2] == 1'b0) ? {12'd0, r_start} : 32'd0;

    assign o_stall    = (r_state != S_IDLE);
    assign accept     = i_valid && !o_stall;
    assign o_valid    = r_ovalid;
    assign o_out_word = r_out;

    assign load_ok  = (i_in_word.address <= ADDR_LIMIT) &&
                      ({1'b0, i_in_word.address} < MEM_LIM);
    assign pc_ok    = ({1'b0, r_pc} < MEM_LIM);
    assign word_bad = r_rdata[31] || (r_rdata > WORD_LIMIT);

    // word / 1000000 by reciprocal multiply in fetch; the remainder follows in the next state (S_DEC).
    // r_rdata still holds the instruction word in both states (no write; pc unchanged unless a config write lands).
    assign dec_prod = {31'd0, r_rdata} * {32'd0, DEC_RECIP};
    assign dec_rem  = r_rdata - (32'(r_q) * DEC_DIVISOR);

    // opcode = q / 10 by reciprocal (exact for q < 1029), register digit = remainder
    assign q_scaled = 18'(r_q) * 18'd205;
    assign opc_c    = q_scaled[17:11];
    assign reg_c    = 4'(r_q - 10'(opc_c) * 10'd10);

    assign rv = r_regs[r_reg];
    assign m  = r_rdata;
    assign opnd_fault = (r_opc >= OPC_ADD) && (r_opc <= OPC_WRITE) &&
                        ({1'b0, r_a} >= MEM_LIM);

    // execute outcome: status and next pc
    always_comb begin
        ex_fault  = opnd_fault || (r_opc == OPC_ERR) || (r_opc == OPC_DIV && m == 32'd0);
        ex_status = ST_EXEC;
        ex_npc    = r_pc + 20'd1;
        if (ex_fault) begin
            ex_status = ST_ERRSTOP;
            ex_npc    = r_pc;
        end else begin
            unique case (r_opc)
                OPC_WRITE: ex_status = ST_WROTE;
                OPC_BR:    ex_npc = r_a;
                OPC_BRN: begin
                    if (rv[31]) begin
                        ex_npc = r_a;
                    end
                end
                OPC_BRZ: begin
                    if (rv == 32'd0) begin
                        ex_npc = r_a;
                    end
                end
                OPC_BRP: begin
                    if (rv != 32'd0 && !rv[31]) begin
                        ex_npc = r_a;
                    end
                end
                OPC_HALT: begin
                    ex_status = ST_HALTED;
                    ex_npc    = r_pc;
                end
                default: begin
                end
            endcase
        end
    end

    // memory: one write and one registered read per cycle, with separate write and read addresses
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = 32'd0;
        mem_ra = r_pc[MEM_AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                if (accept && i_in_word.op == OP_LOAD && load_ok) begin
                    mem_we = 1'b1;
                    mem_wa = i_in_word.address[MEM_AW-1:0];
                    mem_wd = i_in_word.data;
                end
            end
            S_DIGIT: begin
                mem_ra = r_a[MEM_AW-1:0];
            end
            S_EXEC: begin
                mem_wa = r_a[MEM_AW-1:0];
                if (!opnd_fault && r_opc == OPC_STORE) begin
                    mem_we = 1'b1;
                    mem_wd = rv;
                end else if (!opnd_fault && r_opc == OPC_READ) begin
                    mem_we = 1'b1;
                    mem_wd = r_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    // divider for the divide opcode, on magnitudes
    always_comb begin
        div_req = '0;
        if (r_state == S_EXEC && !ex_fault && r_opc == OPC_DIV) begin
            div_req.start    = 1'b1;
            div_req.dividend = rv[31] ? (32'd0 - rv) : rv;
            div_req.divisor  = m[31] ? (32'd0 - m) : m;
        end
    end

    dwcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_start  <= START_RESET;
            r_pc     <= START_RESET;
            r_run    <= RUN_GO;
            r_ovalid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= 32'd0;
            end
        end else begin
            // in S_FIN the output register is refilled instead
            if (r_ovalid && !i_stall && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_wr) begin
                r_start <= pwdata[19:0];
                r_pc    <= pwdata[19:0];
                r_run   <= RUN_GO;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == MEM_AW'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_data          <= i_in_word.data;
                        r_res.out_value <= 32'sd0;
                        r_res.data_used <= 1'b0;
                        r_res.next_pc   <= r_pc;
                        if (i_in_word.op == OP_LOAD) begin
                            r_res.status <= load_ok ? ST_LOADED : ST_REJECT;
                            r_state      <= S_FIN;
                        end else if (r_run != RUN_GO) begin
                            r_res.status <= ST_NOTRUN;
                            r_state      <= S_FIN;
                        end else if (!pc_ok) begin
                            r_res.status <= ST_ERRSTOP;
                            r_run        <= RUN_ERR;
                            r_state      <= S_FIN;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    if (word_bad) begin
                        r_res.status <= ST_ERRSTOP;
                        r_run        <= RUN_ERR;
                        r_state      <= S_FIN;
                    end else begin
                        r_q     <= dec_prod[59:50];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_a     <= dec_rem[19:0];
                    r_state <= S_DIGIT;
                end
                S_DIGIT: begin
                    r_opc   <= opc_c;
                    r_reg   <= reg_c;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_res.status  <= ex_status;
                    r_res.next_pc <= ex_npc;
                    r_pc          <= ex_npc;
                    r_state       <= (!ex_fault && r_opc == OPC_DIV) ? S_DIV : S_FIN;
                    if (ex_fault) begin
                        r_run <= RUN_ERR;
                    end else begin
                        unique case (r_opc)
                            OPC_ADD:   r_regs[r_reg] <= rv + m;
                            OPC_SUB:   r_regs[r_reg] <= rv - m;
                            OPC_MUL:   r_regs[r_reg] <= rv * m;
                            OPC_DIV:   r_neg <= rv[31] ^ m[31];
                            OPC_LOAD:  r_regs[r_reg] <= m;
                            OPC_READ:  r_res.data_used <= 1'b1;
                            OPC_WRITE: r_res.out_value <= m;
                            OPC_HALT:  r_run <= RUN_HALT;
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_regs[r_reg] <= r_neg ? (32'd0 - div_rsp.quot) : div_rsp.quot;
                        r_state       <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CHK_RST(a_clear_quiet, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !r_ovalid)
    `CHK_RST(a_notrun, i_clk, i_rst_n,
        (accept && i_in_word.op == OP_STEP && r_run != RUN_GO) |=>
        (r_state == S_FIN && r_res.status == ST_NOTRUN))
    `CHK_RST(a_div_wait, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (div_rsp.busy || div_rsp.done))

endmodule
`default_nettype wire

// ===== hw/rtl/dwcs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Unsigned restoring divider, one quotient bit per cycle; done is set together with the last quotient bit.
module dwcs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dwcs_pkg::t_div_req i_req,
    output dwcs_pkg::t_div_rsp     o_rsp
);
    import dwcs_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    assign rem_sh  = {r_rem, r_quo[31]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!rem_sub[32]) begin
                    r_rem <= rem_sub[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    `CHK_RST(a_start_idle, i_clk, i_rst_n, i_req.start |-> !r_busy)
    `CHK_RST(a_nonzero_dvs, i_clk, i_rst_n, i_req.start |-> (i_req.divisor != 32'd0))
    `CHK_RST(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))

endmodule
`default_nettype wire
